@@ rtl/dtbg_pkg.sv @@
// shared types and constants of the decaying tone burst generator
package dtbg_pkg;

  localparam int SINE_TABLE_DEPTH_DEF = 1024;
  localparam int TANH_TABLE_DEPTH_DEF = 1024;
  localparam int CLICK_SAMPLES_DEF    = 96;
  localparam int COUNT_BITS_DEF       = 20;

  localparam int PHASE_W    = 32;
  localparam int ATTACK_W   = 20;
  localparam int INTERVAL_W = 20;
  localparam int DECAY_W    = 24;
  localparam int ENV_W      = 24;
  localparam int SAMPLE_W   = 16;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 4;

  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 20'd48000;
  localparam logic [ENV_W-1:0]      ENV_ONE        = 24'd8388608;
  localparam logic [ENV_W-1:0]      ENV_MAX        = 24'hFFFFFF;

  typedef enum logic [1:0] {
    REG_PHASE_STEP      = 2'd0,
    REG_ATTACK_LENGTH   = 2'd1,
    REG_INTERVAL_LENGTH = 2'd2,
    REG_DECAY_FACTOR    = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    MUL_SIDX = 2'd0,
    MUL_TONE = 2'd1,
    MUL_TIDX = 2'd2,
    MUL_ENV  = 2'd3
  } mul_sel_t;

  typedef struct packed {
    logic [PHASE_W-1:0]    phase_step;
    logic [ATTACK_W-1:0]   attack_length;
    logic [INTERVAL_W-1:0] interval_length;
    logic [DECAY_W-1:0]    decay_factor;
  } cfg_t;

  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     srom_rd;
    logic     xval;
    logic     trom_rd;
    logic     out_wr;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

@@ rtl/dtbg_regs.sv @@
// configuration register file behind the apb-style port
module dtbg_regs
  import dtbg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.phase_step      <= '0;
      cfg_r.attack_length   <= '0;
      cfg_r.interval_length <= INTERVAL_RESET;
      cfg_r.decay_factor    <= ENV_ONE;
    end else if (wr_en) begin
      case (idx)
        REG_PHASE_STEP:      cfg_r.phase_step      <= pwdata[PHASE_W-1:0];
        REG_ATTACK_LENGTH:   cfg_r.attack_length   <= pwdata[ATTACK_W-1:0];
        REG_INTERVAL_LENGTH: cfg_r.interval_length <= pwdata[INTERVAL_W-1:0];
        REG_DECAY_FACTOR:    cfg_r.decay_factor    <= pwdata[DECAY_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_PHASE_STEP:      prdata = CFG_DATA_W'(cfg_r.phase_step);
      REG_ATTACK_LENGTH:   prdata = CFG_DATA_W'(cfg_r.attack_length);
      REG_INTERVAL_LENGTH: prdata = CFG_DATA_W'(cfg_r.interval_length);
      REG_DECAY_FACTOR:    prdata = CFG_DATA_W'(cfg_r.decay_factor);
      default:             prdata = '0;
    endcase
  end

endmodule

@@ rtl/dtbg_ctrl.sv @@
// sequencer that steps the datapath through one sample
module dtbg_ctrl
  import dtbg_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SIDX,
    S_SROM,
    S_TONE,
    S_XVAL,
    S_TIDX,
    S_TROM,
    S_OUT
  } state_t;

  state_t state_r;
  logic   in_tready_r;

  assign in_tready = in_tready_r;

  always_comb begin
    cmd = '0;
    case (state_r)
      S_IDLE: cmd.load = in_tvalid && in_tready_r;
      S_SIDX: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_SIDX;
      end
      S_SROM: cmd.srom_rd = 1'b1;
      S_TONE: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_TONE;
      end
      S_XVAL: cmd.xval = 1'b1;
      S_TIDX: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_TIDX;
      end
      S_TROM: begin
        cmd.trom_rd = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_ENV;
      end
      S_OUT: cmd.out_wr = sts.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_tready_r <= 1'b1;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_tvalid && in_tready_r) begin
            state_r     <= S_SIDX;
            in_tready_r <= 1'b0;
          end
        end
        S_SIDX: state_r <= S_SROM;
        S_SROM: state_r <= S_TONE;
        S_TONE: state_r <= S_XVAL;
        S_XVAL: state_r <= S_TIDX;
        S_TIDX: state_r <= S_TROM;
        S_TROM: state_r <= S_OUT;
        S_OUT: begin
          if (sts.out_free) begin
            state_r     <= S_IDLE;
            in_tready_r <= 1'b1;
          end
        end
        default: begin
          state_r     <= S_IDLE;
          in_tready_r <= 1'b1;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready_r |=> state_r == S_SIDX)
    else $error("accepted word did not start the sequence");

  a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SIDX |-> ##6 state_r == S_OUT)
    else $error("sequence did not reach the output step in six cycles");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_OUT && !sts.out_free |=> state_r == S_OUT && !in_tready_r)
    else $error("output step left while output register full");
`endif

endmodule

@@ rtl/dtbg_dp.sv @@
// datapath: counters, phase, envelope, shared multiplier, sine and tanh roms
module dtbg_dp
  import dtbg_pkg::*;
#(
  parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF,
  parameter int TANH_TABLE_DEPTH = TANH_TABLE_DEPTH_DEF,
  parameter int CLICK_SAMPLES    = CLICK_SAMPLES_DEF,
  parameter int COUNT_BITS       = COUNT_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  cfg_t                       cfg,
  input  cmd_t                       cmd,
  output sts_t                       sts,
  input  logic                       restart,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic signed [SAMPLE_W-1:0] out_sample,
  output logic                       out_attack,
  output logic                       out_pstart
);

  localparam int SIDX_W = $clog2(SINE_TABLE_DEPTH);
  localparam int TIDX_W = $clog2(TANH_TABLE_DEPTH);
  localparam int CMP_W  = ((COUNT_BITS > INTERVAL_W) ? COUNT_BITS : INTERVAL_W) + 1;
  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 24;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int AX_W    = 19;
  localparam int COMB_W  = 18;
  localparam int TANH_SHIFT = 18;

  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] TWO_PI_Q30  = 64'd6746518852;
  localparam logic [63:0] PI_Q30      = 64'd3373259426;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] INV_E_Q30   = 64'd395007542;
  localparam logic signed [COMB_W-1:0] CLICK_Q15 = 18'sd26214;
  localparam logic [14:0] TANH_FULL = 15'd32767;

  typedef logic [SINE_TABLE_DEPTH-1:0][15:0] srom_t;
  typedef logic [TANH_TABLE_DEPTH-1:0][14:0] trom_t;

  // shift-and-subtract quotient, used only while the roms are built
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic logic [63:0] sin_q30(input logic [63:0] th);
    logic signed [63:0] acc;
    logic [63:0]        term;
    acc  = $signed(th);
    term = th;
    for (int k = 1; k <= 6; k++) begin
      term = (term * th) >> 30;
      term = (term * th) >> 30;
      term = udiv64(term, 64'((2 * k) * (2 * k + 1)));
      if (k[0]) acc = acc - $signed(term);
      else acc = acc + $signed(term);
    end
    return (acc < 0) ? 64'd0 : 64'(acc);
  endfunction

  function automatic logic [63:0] expneg_q30(input logic [63:0] f);
    logic signed [63:0] acc;
    logic [63:0]        term;
    acc  = $signed(Q30_ONE);
    term = Q30_ONE;
    for (int k = 1; k <= 12; k++) begin
      term = udiv64((term * f) >> 30, 64'(k));
      if (k[0]) acc = acc - $signed(term);
      else acc = acc + $signed(term);
    end
    return (acc < 0) ? 64'd0 : 64'(acc);
  endfunction

  function automatic srom_t build_sine();
    srom_t       tab;
    logic [63:0] th;
    logic [63:0] v;
    logic        neg;
    for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
      th  = TWO_PI_Q30 * 64'(k) / 64'(SINE_TABLE_DEPTH);
      neg = 1'b0;
      if (th >= PI_Q30) begin
        th  = th - PI_Q30;
        neg = 1'b1;
      end
      if (th > HALF_PI_Q30) th = PI_Q30 - th;
      v = (sin_q30(th) + 64'd16384) >> 15;
      if (v > 64'd32767) v = 64'd32767;
      tab[k] = neg ? (16'd0 - 16'(v)) : 16'(v);
    end
    return tab;
  endfunction

  function automatic trom_t build_tanh();
    trom_t       tab;
    logic [63:0] z;
    logic [63:0] e;
    logic [63:0] t;
    logic [63:0] v;
    for (int j = 0; j < TANH_TABLE_DEPTH; j++) begin
      z = (64'(j) << 34) / 64'(TANH_TABLE_DEPTH);
      e = expneg_q30(z & (Q30_ONE - 64'd1));
      for (int n = 0; n < int'(z >> 30); n++) e = (e * INV_E_Q30) >> 30;
      if (e > Q30_ONE) e = Q30_ONE;
      t = udiv64((Q30_ONE - e) << 30, Q30_ONE + e);
      v = (t + 64'd16384) >> 15;
      if (v > 64'd32767) v = 64'd32767;
      tab[j] = 15'(v);
    end
    return tab;
  endfunction

  localparam srom_t SINE_ROM = build_sine();
  localparam trom_t TANH_ROM = build_tanh();

  // sample state
  logic [COUNT_BITS-1:0] count_r;
  logic [PHASE_W-1:0]    phase_r;
  logic [ENV_W-1:0]      env_r;

  // per-word working registers
  logic [COUNT_BITS-1:0]     n_r;
  logic                      attack_r;
  logic                      click_r;
  logic                      pstart_r;
  logic                      wrap_r;
  logic [PROD_W-1:0]         prod_r;
  logic signed [15:0]        srom_r;
  logic                      xneg_r;
  logic [AX_W-1:0]           ax_r;
  logic                      tsat_r;
  logic [14:0]               trom_r;

  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;
  logic                       out_attack_r;
  logic                       out_pstart_r;

  // load decode
  logic [INTERVAL_W-1:0] ilen;
  logic                  reset_now;
  logic [COUNT_BITS-1:0] n_cur;

  assign ilen      = (cfg.interval_length == '0) ? INTERVAL_W'(1) : cfg.interval_length;
  assign reset_now = restart || (CMP_W'(count_r) >= CMP_W'(ilen));
  assign n_cur     = reset_now ? '0 : count_r;

  // shared multiplier
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  prod_nxt;
  logic [14:0]        mag;

  assign mag = srom_r[15] ? 15'(-srom_r) : srom_r[14:0];

  always_comb begin
    case (cmd.mul_sel)
      MUL_SIDX: begin
        mul_a = phase_r;
        mul_b = MUL_B_W'(SINE_TABLE_DEPTH);
      end
      MUL_TONE: begin
        mul_a = MUL_A_W'(env_r);
        mul_b = MUL_B_W'(mag);
      end
      MUL_TIDX: begin
        mul_a = MUL_A_W'(ax_r);
        mul_b = MUL_B_W'(TANH_TABLE_DEPTH);
      end
      MUL_ENV: begin
        mul_a = MUL_A_W'(env_r);
        mul_b = MUL_B_W'(cfg.decay_factor);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_nxt = PROD_W'(mul_a) * PROD_W'(mul_b);

  // tone, click and tanh argument
  logic [39:0]              tone_sum;
  logic [16:0]              tone_mag;
  logic signed [COMB_W-1:0] tone;
  logic signed [COMB_W-1:0] comb_val;
  logic signed [COMB_W+1:0] x_val;
  logic [AX_W-1:0]          ax_nxt;

  assign tone_sum = 40'(prod_r[38:0]) + 40'd4194304;
  assign tone_mag = tone_sum[39:23];
  assign tone     = srom_r[15] ? -$signed(COMB_W'(tone_mag)) : $signed(COMB_W'(tone_mag));
  assign comb_val = tone + (click_r ? CLICK_Q15 : '0);
  assign x_val    = {comb_val, 2'b00};
  assign ax_nxt   = x_val[COMB_W+1] ? AX_W'(-x_val) : AX_W'(x_val);

  // tanh index
  logic [TIDX_W:0] ti;
  assign ti = prod_r[TANH_SHIFT +: TIDX_W+1];

  // result and state update
  logic [14:0]                tv;
  logic signed [SAMPLE_W-1:0] sample_nxt;
  logic [ENV_W:0]             env_prod;
  logic [ENV_W-1:0]           env_nxt;
  logic                       out_free;

  assign tv         = tsat_r ? TANH_FULL : trom_r;
  assign sample_nxt = !attack_r ? '0 :
                      (xneg_r ? -$signed(SAMPLE_W'(tv)) : $signed(SAMPLE_W'(tv)));
  assign env_prod   = prod_r[2*ENV_W-1:ENV_W-1];
  assign env_nxt    = env_prod[ENV_W] ? ENV_MAX : env_prod[ENV_W-1:0];
  assign out_free   = !out_valid_r || out_ready;
  assign sts.out_free = out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      phase_r <= '0;
      env_r   <= ENV_ONE;
    end else if (cmd.load && reset_now) begin
      phase_r <= '0;
      env_r   <= ENV_ONE;
    end else if (cmd.out_wr) begin
      if (wrap_r) begin
        count_r <= '0;
        phase_r <= '0;
        env_r   <= ENV_ONE;
      end else begin
        count_r <= COUNT_BITS'(n_r + 1'b1);
        phase_r <= phase_r + cfg.phase_step;
        env_r   <= env_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n_r      <= n_cur;
      attack_r <= CMP_W'(n_cur) < CMP_W'(cfg.attack_length);
      click_r  <= CMP_W'(n_cur) < CMP_W'(CLICK_SAMPLES);
      pstart_r <= n_cur == '0;
      wrap_r   <= (CMP_W'(n_cur) + CMP_W'(1)) >= CMP_W'(ilen);
    end
    if (cmd.mul_en) prod_r <= prod_nxt;
    if (cmd.srom_rd) srom_r <= $signed(SINE_ROM[prod_r[32 +: SIDX_W]]);
    if (cmd.xval) begin
      xneg_r <= x_val[COMB_W+1];
      ax_r   <= ax_nxt;
    end
    if (cmd.trom_rd) begin
      tsat_r <= (TIDX_W+1)'(TANH_TABLE_DEPTH) <= ti;
      trom_r <= TANH_ROM[ti[TIDX_W-1:0]];
    end
    if (cmd.out_wr) begin
      out_sample_r <= sample_nxt;
      out_attack_r <= attack_r;
      out_pstart_r <= pstart_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_wr) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;
  assign out_attack = out_attack_r;
  assign out_pstart = out_pstart_r;

`ifndef SYNTHESIS
  a_silent_outside_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_attack_r |-> out_sample_r == '0)
    else $error("nonzero sample outside the tone burst");
`endif

endmodule

@@ rtl/decaying_tone_burst_generator.sv @@
// top level of the decaying tone burst generator
//
// in_*  : one word per sample tick; in_tdata[0] is restart, which makes the
//         tick sample zero of a new period.
// out_* : one word per tick; out_tdata is the signed q1.15 sample,
//         out_tuser[0] flags samples inside the tone burst and
//         out_tuser[1] the first sample of each period.
// cfg_* : apb-style port with phase_step, attack_length, interval_length
//         and decay_factor at byte addresses 0, 4, 8 and 12; write only
//         while no word is in flight.
// sequencing: a new word is taken only once the last one is written to the
//         output register; the sequencer steps a single shared 32x24
//         multiplier through sine index, tone gain, tanh index and envelope
//         decay, with registered sine and tanh rom reads interleaved.
// a finished word sits in the output register; while the receiver stalls
//         the next word may be accepted and worked on, and it waits in its
//         last step until the output register frees.
// reset (rst_n low, synchronous) clears the counter and phase, sets the
//         envelope to 1.0 and loads the register defaults.
module decaying_tone_burst_generator
  import dtbg_pkg::*;
#(
  parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF,
  parameter int TANH_TABLE_DEPTH = TANH_TABLE_DEPTH_DEF,
  parameter int CLICK_SAMPLES    = CLICK_SAMPLES_DEF,
  parameter int COUNT_BITS       = COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,    // [0] restart, [7:1] zero
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [SAMPLE_W-1:0]   out_tdata,   // [15:0] sample
  output logic [1:0]            out_tuser,   // [0] in_attack, [1] period_start
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  logic signed [SAMPLE_W-1:0] sample;
  logic                       in_attack;
  logic                       period_start;

  dtbg_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  dtbg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  dtbg_dp #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
    .TANH_TABLE_DEPTH (TANH_TABLE_DEPTH),
    .CLICK_SAMPLES    (CLICK_SAMPLES),
    .COUNT_BITS       (COUNT_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .cmd        (cmd),
    .sts        (sts),
    .restart    (in_tdata[0]),
    .out_ready  (out_tready),
    .out_valid  (out_tvalid),
    .out_sample (sample),
    .out_attack (in_attack),
    .out_pstart (period_start)
  );

  assign out_tdata = sample;
  assign out_tuser = {period_start, in_attack};

endmodule
